>>> hdl/transport_receiver_connection_table_defines.svh
// ----------------------------------------------------------------------------
// Connection table assertion macros
// Shared concurrent assertion helpers for the transport receiver table.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_RECEIVER_CONNECTION_TABLE_DEFINES_SVH
`define TRANSPORT_RECEIVER_CONNECTION_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define TRCT_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("connection table assertion failed");
// Next-cycle implication, checked out of reset.
`define TRCT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("connection table assertion failed");
`else
`define TRCT_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define TRCT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

>>> hdl/trct_pkg.sv
// ----------------------------------------------------------------------------
// Connection table package
// Codes, field widths and parameter defaults for the transport receiver table.
// ----------------------------------------------------------------------------
package trct_pkg;

    // Parameter defaults.
    localparam int NUM_CONNECTIONS_DEF = 8;
    localparam int BUFFER_BYTES_DEF    = 4096;

    // Fixed field widths.
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int PORT_W   = 16;
    localparam int SEQ_W    = 32;
    localparam int CNT_W    = 13;
    localparam int SID_W    = 3;
    localparam int STATUS_W = 3;
    localparam int REPLY_W  = 2;
    localparam int MODE_W   = 2;

    // Operations.
    localparam logic [OP_W-1:0] OP_OPEN    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEGMENT = 2'd1;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;
    localparam logic [OP_W-1:0] OP_CLOSE   = 2'd3;

    // Segment kinds.
    localparam logic [KIND_W-1:0] SEG_SYN   = 2'd0;
    localparam logic [KIND_W-1:0] SEG_FIN   = 2'd1;
    localparam logic [KIND_W-1:0] SEG_DATA  = 2'd2;
    localparam logic [KIND_W-1:0] SEG_OTHER = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DATA  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

    // Reply kinds.
    localparam logic [REPLY_W-1:0] RPL_SYNACK  = 2'd0;
    localparam logic [REPLY_W-1:0] RPL_FINACK  = 2'd1;
    localparam logic [REPLY_W-1:0] RPL_DATAACK = 2'd2;

    // Connection modes.
    localparam logic [MODE_W-1:0] MODE_CLOSED     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECTED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE_WAIT = 2'd2;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

endpackage

>>> hdl/transport_receiver_connection_table.sv
// ----------------------------------------------------------------------------
// Transport receiver connection table
// Server-side connection table: open, segment handling, consume and close.
// ----------------------------------------------------------------------------
// Result: the accepting edge starts the lookup cycle, then the read-modify-write
// cycle; o_valid and the result fields are registered at the end of that cycle.
// Acceptance: busy covers the lookup cycle (port search, connection record memory read);
// a new operation may be taken during the read-modify-write cycle.
// Reset: synchronous reset empties the table at once; no clearing pass is needed.
`include "transport_receiver_connection_table_defines.svh"

module transport_receiver_connection_table #(
    parameter int NUM_CONNECTIONS = trct_pkg::NUM_CONNECTIONS_DEF,
    parameter int BUFFER_BYTES    = trct_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [trct_pkg::OP_W-1:0]       i_operation,
    input  logic [trct_pkg::KIND_W-1:0]     i_seg_kind,
    input  logic [trct_pkg::PORT_W-1:0]     i_port,
    input  logic [trct_pkg::PORT_W-1:0]     i_peer_port,
    input  logic [trct_pkg::SEQ_W-1:0]      i_seq_number,
    input  logic [trct_pkg::CNT_W-1:0]      i_byte_count,
    input  logic [trct_pkg::SID_W-1:0]      i_socket_id,
    output logic                            o_valid,
    output logic [trct_pkg::STATUS_W-1:0]   o_status,
    output logic [trct_pkg::SID_W-1:0]      o_entry_index,
    output logic                            o_send_reply,
    output logic [trct_pkg::REPLY_W-1:0]    o_reply_kind,
    output logic [trct_pkg::PORT_W-1:0]     o_reply_src_port,
    output logic [trct_pkg::PORT_W-1:0]     o_reply_dest_port,
    output logic [trct_pkg::SEQ_W-1:0]      o_reply_ack,
    output logic [trct_pkg::CNT_W-1:0]      o_occupancy,
    output logic [trct_pkg::MODE_W-1:0]     o_conn_mode
);

    localparam int IDX_W   = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
    localparam int OCC_W   = $clog2(BUFFER_BYTES);
    localparam int SUM_W   = ((OCC_W > trct_pkg::CNT_W) ? OCC_W : trct_pkg::CNT_W) + 1;
    localparam int PORT_W  = trct_pkg::PORT_W;
    localparam int SEQ_W   = trct_pkg::SEQ_W;
    localparam int CNT_W   = trct_pkg::CNT_W;
    localparam int SID_W   = trct_pkg::SID_W;
    localparam int REC_W   = PORT_W + SEQ_W + OCC_W;

    // Sequencer and latched operation.
    logic [1:0]                     r_state, n_state;
    logic [trct_pkg::OP_W-1:0]      r_op;
    logic [trct_pkg::KIND_W-1:0]    r_kind;
    logic [PORT_W-1:0]              r_port;
    logic [PORT_W-1:0]              r_peer;
    logic [SEQ_W-1:0]               r_seq;
    logic [CNT_W-1:0]               r_cnt;
    logic [SID_W-1:0]               r_sid;
    logic [IDX_W-1:0]               r_idx;
    logic                           r_hit;

    // Per-entry control flops and bound server ports (searched in parallel).
    logic [NUM_CONNECTIONS-1:0]     r_used;
    logic [trct_pkg::MODE_W-1:0]    r_mode  [NUM_CONNECTIONS];
    logic [PORT_W-1:0]              r_lport [NUM_CONNECTIONS];

    // Connection record memory: client port, expected sequence, occupancy.
    logic [REC_W-1:0]               r_mem   [NUM_CONNECTIONS];
    logic [REC_W-1:0]               r_rd;

    // Output registers.
    logic                           r_valid;
    logic [trct_pkg::STATUS_W-1:0]  r_status,  n_status;
    logic [SID_W-1:0]               r_eidx,    n_eidx;
    logic                           r_send,    n_send;
    logic [trct_pkg::REPLY_W-1:0]   r_rkind,   n_rkind;
    logic [PORT_W-1:0]              r_src,     n_src;
    logic [PORT_W-1:0]              r_dst,     n_dst;
    logic [SEQ_W-1:0]               r_ack,     n_ack;
    logic [CNT_W-1:0]               r_occ,     n_occ;
    logic [trct_pkg::MODE_W-1:0]    r_cmode,   n_cmode;

    // Lookup results.
    logic                           match_hit, free_hit;
    logic [IDX_W-1:0]               match_idx, free_idx;
    logic                           lk_hit;
    logic [IDX_W-1:0]               lk_idx;

    // Update path.
    logic [PORT_W-1:0]              rd_remote;
    logic [SEQ_W-1:0]               rd_exp;
    logic [OCC_W-1:0]               rd_buf;
    logic [trct_pkg::MODE_W-1:0]    cur_mode;
    logic [PORT_W-1:0]              cur_lport;
    logic [SEQ_W-1:0]               seq_p1;
    logic [SUM_W-1:0]               data_sum;
    logic                           wr_en, set_used, clr_used, do_fill;
    logic [PORT_W-1:0]              new_lport, new_remote;
    logic [SEQ_W-1:0]               new_exp;
    logic [OCC_W-1:0]               new_buf;
    logic [trct_pkg::MODE_W-1:0]    new_mode;

    logic                           accept;

    assign busy   = (r_state == trct_pkg::S_LOOK);
    assign accept = start && !busy;

    // Sequencer: lookup cycle, then read-modify-write cycle. A new transfer may
    // be taken during the write cycle; its lookup sees the written state.
    always_comb begin
        case (r_state)
            trct_pkg::S_IDLE: begin
                n_state = accept ? trct_pkg::S_LOOK : trct_pkg::S_IDLE;
            end
            trct_pkg::S_LOOK: begin
                n_state = trct_pkg::S_EXEC;
            end
            trct_pkg::S_EXEC: begin
                n_state = accept ? trct_pkg::S_LOOK : trct_pkg::S_IDLE;
            end
            default: begin
                n_state = trct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trct_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == trct_pkg::S_EXEC);
        end
    end

    // Latch the operation on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_kind <= i_seg_kind;
            r_port <= i_port;
            r_peer <= i_peer_port;
            r_seq  <= i_seq_number;
            r_cnt  <= i_byte_count;
            r_sid  <= i_socket_id;
        end
    end

    // Port match and free-entry search over the table.
    trct_search #(
        .NUM_CONNECTIONS (NUM_CONNECTIONS),
        .IDX_W           (IDX_W)
    ) u_search (
        .i_used      (r_used),
        .i_ports     (r_lport),
        .i_key       (r_port),
        .o_match_hit (match_hit),
        .o_match_idx (match_idx),
        .o_free_hit  (free_hit),
        .o_free_idx  (free_idx)
    );

    // Pick the target entry for the operation.
    always_comb begin
        case (r_op)
            trct_pkg::OP_OPEN: begin
                lk_hit = free_hit;
                lk_idx = free_idx;
            end
            trct_pkg::OP_SEGMENT: begin
                lk_hit = match_hit && (r_kind != trct_pkg::SEG_OTHER);
                lk_idx = match_idx;
            end
            default: begin
                lk_idx = IDX_W'(r_sid);
                lk_hit = (32'(r_sid) < NUM_CONNECTIONS) && r_used[lk_idx];
            end
        endcase
    end

    // Lookup cycle: register the target and read its record.
    always_ff @(posedge i_clk) begin
        if (r_state == trct_pkg::S_LOOK) begin
            r_idx <= lk_idx;
            r_hit <= lk_hit;
            r_rd  <= r_mem[lk_idx];
        end
    end

    assign rd_remote = r_rd[REC_W-1 -: PORT_W];
    assign rd_exp    = r_rd[OCC_W +: SEQ_W];
    assign rd_buf    = r_rd[OCC_W-1:0];
    assign cur_mode  = r_mode[r_idx];
    assign cur_lport = r_lport[r_idx];
    assign seq_p1    = r_seq + 32'd1;
    assign data_sum  = SUM_W'(rd_buf) + SUM_W'(r_cnt);

    // Read-modify-write cycle: new entry contents and the result fields.
    always_comb begin
        n_status   = trct_pkg::ST_OK;
        n_eidx     = '0;
        n_send     = 1'b0;
        n_rkind    = trct_pkg::RPL_SYNACK;
        n_src      = '0;
        n_dst      = '0;
        n_ack      = '0;
        n_occ      = '0;
        n_cmode    = trct_pkg::MODE_CLOSED;
        wr_en      = 1'b0;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        do_fill    = 1'b0;
        new_lport  = cur_lport;
        new_remote = rd_remote;
        new_exp    = rd_exp;
        new_buf    = rd_buf;
        new_mode   = cur_mode;
        case (r_op)
            trct_pkg::OP_OPEN: begin
                if (!r_hit) begin
                    n_status = trct_pkg::ST_FULL;
                end else begin
                    set_used   = 1'b1;
                    wr_en      = 1'b1;
                    do_fill    = 1'b1;
                    new_lport  = r_port;
                    new_remote = '0;
                    new_exp    = '0;
                    new_buf    = '0;
                    new_mode   = trct_pkg::MODE_CLOSED;
                end
            end
            trct_pkg::OP_SEGMENT: begin
                if (r_kind == trct_pkg::SEG_OTHER) begin
                    n_status = trct_pkg::ST_IGNORED;
                end else if (!r_hit) begin
                    n_status = trct_pkg::ST_NO_MATCH;
                end else begin
                    wr_en   = 1'b1;
                    do_fill = 1'b1;
                    n_send  = 1'b1;
                    case (r_kind)
                        trct_pkg::SEG_SYN: begin
                            new_remote = r_peer;
                            new_mode   = trct_pkg::MODE_CONNECTED;
                            new_exp    = seq_p1;
                            n_rkind    = trct_pkg::RPL_SYNACK;
                            n_ack      = seq_p1;
                        end
                        trct_pkg::SEG_FIN: begin
                            new_mode = trct_pkg::MODE_CLOSE_WAIT;
                            n_rkind  = trct_pkg::RPL_FINACK;
                            n_ack    = seq_p1;
                        end
                        default: begin
                            // In-order data advances; a buffer-filling payload drops.
                            if (r_seq == rd_exp) begin
                                new_exp = seq_p1;
                                if (data_sum < SUM_W'(BUFFER_BYTES)) begin
                                    new_buf = OCC_W'(data_sum);
                                end
                            end
                            n_rkind = trct_pkg::RPL_DATAACK;
                            n_ack   = new_exp;
                        end
                    endcase
                end
            end
            trct_pkg::OP_CONSUME: begin
                if (!r_hit) begin
                    n_status = trct_pkg::ST_BAD;
                    n_eidx   = r_sid;
                end else begin
                    do_fill = 1'b1;
                    if (SUM_W'(rd_buf) >= SUM_W'(r_cnt)) begin
                        wr_en   = 1'b1;
                        new_buf = rd_buf - OCC_W'(r_cnt);
                    end else begin
                        n_status = trct_pkg::ST_NO_DATA;
                    end
                end
            end
            default: begin
                if (!r_hit) begin
                    n_status = trct_pkg::ST_BAD;
                    n_eidx   = r_sid;
                end else begin
                    do_fill = 1'b1;
                    if (cur_mode == trct_pkg::MODE_CLOSE_WAIT) begin
                        clr_used   = 1'b1;
                        wr_en      = 1'b1;
                        new_lport  = '0;
                        new_remote = '0;
                        new_exp    = '0;
                        new_buf    = '0;
                        new_mode   = trct_pkg::MODE_CLOSED;
                    end else begin
                        n_status = trct_pkg::ST_BAD;
                    end
                end
            end
        endcase
        // Report the entry as it stands after the update.
        if (do_fill) begin
            n_eidx  = SID_W'(r_idx);
            n_src   = new_lport;
            n_dst   = new_remote;
            n_occ   = CNT_W'(new_buf);
            n_cmode = new_mode;
        end
    end

    // Entry control flops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int k = 0; k < NUM_CONNECTIONS; k++) begin
                r_mode[k] <= trct_pkg::MODE_CLOSED;
            end
        end else if ((r_state == trct_pkg::S_EXEC) && wr_en) begin
            r_mode[r_idx] <= new_mode;
            if (set_used) begin
                r_used[r_idx] <= 1'b1;
            end
            if (clr_used) begin
                r_used[r_idx] <= 1'b0;
            end
        end
    end

    // Write back the record and the bound port.
    always_ff @(posedge i_clk) begin
        if ((r_state == trct_pkg::S_EXEC) && wr_en) begin
            r_mem[r_idx]   <= {new_remote, new_exp, new_buf};
            r_lport[r_idx] <= new_lport;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == trct_pkg::S_EXEC) begin
            r_status <= n_status;
            r_eidx   <= n_eidx;
            r_send   <= n_send;
            r_rkind  <= n_rkind;
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_ack    <= n_ack;
            r_occ    <= n_occ;
            r_cmode  <= n_cmode;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_entry_index     = r_eidx;
    assign o_send_reply      = r_send;
    assign o_reply_kind      = r_rkind;
    assign o_reply_src_port  = r_src;
    assign o_reply_dest_port = r_dst;
    assign o_reply_ack       = r_ack;
    assign o_occupancy       = r_occ;
    assign o_conn_mode       = r_cmode;

    // Each accepted transfer is followed by exactly one lookup cycle.
    `TRCT_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, accept, busy)
    `TRCT_ASSERT_NEXT(a_look_once, i_clk, i_rst_n, busy, !busy)
    // The write cycle always produces a result strobe.
    `TRCT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, (r_state == trct_pkg::S_EXEC), o_valid)
    // Replies are only sent for successful segment handling.
    `TRCT_ASSERT_IMPLY(a_reply_ok, i_clk, i_rst_n, o_valid && o_send_reply, o_status == trct_pkg::ST_OK)
    // A full table reports no entry.
    `TRCT_ASSERT_IMPLY(a_full_zero, i_clk, i_rst_n, o_valid && (o_status == trct_pkg::ST_FULL), o_entry_index == '0)

endmodule

>>> hdl/trct_search.sv
// ----------------------------------------------------------------------------
// Connection table search
// Finds the lowest free entry and the lowest used entry bound to a port.
// ----------------------------------------------------------------------------
module trct_search #(
    parameter int NUM_CONNECTIONS = trct_pkg::NUM_CONNECTIONS_DEF,
    parameter int IDX_W           = 3
) (
    input  logic [NUM_CONNECTIONS-1:0]    i_used,
    input  logic [trct_pkg::PORT_W-1:0]   i_ports [NUM_CONNECTIONS],
    input  logic [trct_pkg::PORT_W-1:0]   i_key,
    output logic                          o_match_hit,
    output logic [IDX_W-1:0]              o_match_idx,
    output logic                          o_free_hit,
    output logic [IDX_W-1:0]              o_free_idx
);

    // Scan from the top down so that the lowest qualifying entry wins.
    always_comb begin
        o_match_hit = 1'b0;
        o_match_idx = '0;
        o_free_hit  = 1'b0;
        o_free_idx  = '0;
        for (int k = NUM_CONNECTIONS - 1; k >= 0; k--) begin
            if (i_used[k] && (i_ports[k] == i_key)) begin
                o_match_hit = 1'b1;
                o_match_idx = IDX_W'(k);
            end
            if (!i_used[k]) begin
                o_free_hit = 1'b1;
                o_free_idx = IDX_W'(k);
            end
        end
    end

endmodule
